/* hw/rtl/msbfa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msbfa_pkg: shared definitions for the MSB-first bit field access unit
// Widths, buffer geometry, command codes, controller states and the
// command and status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package msbfa_pkg;

  // Buffer geometry. The buffer size must be a power of two.
  localparam int BUF_BYTES      = 1024;
  localparam int MAX_FIELD_BITS = 64;
  localparam int ADDR_W         = $clog2(BUF_BYTES);
  localparam int CUR_W          = ADDR_W + 3;

  // Port field widths.
  localparam int CMD_W   = 3;
  localparam int BADDR_W = 10;
  localparam int BYTE_W  = 8;
  localparam int BOFF_W  = 13;
  localparam int CNT_W   = 7;
  localparam int FIELD_W = 64;

  // A field plus a partial leading byte spans this many bits at most.
  localparam int WIN_W = FIELD_W + BYTE_W;
  localparam int NB_W  = $clog2(WIN_W / BYTE_W + 1);

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    OP_STORE = 3'd0,
    OP_SEEK  = 3'd1,
    OP_READ  = 3'd2,
    OP_WRITE = 3'd3,
    OP_SKIP  = 3'd4
  } op_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_READ,
    ST_FETCH,
    ST_BUILD,
    ST_WRITE,
    ST_FINISH
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic mem_rd;
    logic fetch;
    logic build;
    logic mem_wr;
    logic finish;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    op_t  op;
    logic len_zero;
    logic left_zero;
    logic rd_valid;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

/* hw/rtl/msbfa_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msbfa_dpath: datapath of the bit field access unit
// Holds the byte memory, the bit cursor, the byte address counter, the
// read accumulator, the write shift register and the output word register.
// ----------------------------------------------------------------------------
module msbfa_dpath import msbfa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          cmd,
  output dp_sts_t            sts,
  input  logic [CMD_W-1:0]   command,
  input  logic [BADDR_W-1:0] byte_address,
  input  logic [BYTE_W-1:0]  byte_value,
  input  logic [BOFF_W-1:0]  seek_position,
  input  logic [CNT_W-1:0]   bit_count,
  input  logic [FIELD_W-1:0] write_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FIELD_W-1:0] read_value,
  output logic [BOFF_W-1:0]  cursor_position
);

  logic [BYTE_W-1:0]  mem [BUF_BYTES];
  logic [BYTE_W-1:0]  rdata;
  logic               rd_valid;
  logic [CUR_W-1:0]   cursor;
  logic [CUR_W-1:0]   cur_new;
  op_t                op;
  logic               len_zero;
  logic [2:0]         off;
  logic [2:0]         tail;
  logic [NB_W-1:0]    left;
  logic [ADDR_W-1:0]  addr;
  logic [FIELD_W-1:0] mask;
  logic [FIELD_W-1:0] fl;
  logic [WIN_W-1:0]   acc;
  logic [WIN_W-1:0]   sreg;

  logic [CNT_W-1:0]   in_n;
  logic [CNT_W-1:0]   in_sum;
  logic [NB_W-1:0]    in_nb;
  logic [CUR_W-1:0]   in_cur_new;
  logic [NB_W-1:0]    in_left;
  op_t                in_op;
  logic [BYTE_W-1:0]  keep_mask;

  // Decode of the incoming word: field length, span in bytes, new cursor.
  always_comb begin
    in_op  = op_t'(command);
    in_n   = (bit_count > CNT_W'(MAX_FIELD_BITS)) ? CNT_W'(MAX_FIELD_BITS) : bit_count;
    in_sum = CNT_W'({4'b0, cursor[2:0]}) + in_n;
    in_nb  = NB_W'((in_sum + CNT_W'(7)) >> 3);
    in_cur_new = cursor;
    in_left    = '0;
    case (in_op)
      OP_STORE: begin
        in_left = NB_W'(1);
      end
      OP_SEEK: begin
        in_cur_new = CUR_W'(seek_position);
      end
      OP_READ, OP_WRITE: begin
        in_cur_new = cursor + CUR_W'(in_n);
        in_left    = in_nb;
      end
      OP_SKIP: begin
        in_cur_new = cursor + CUR_W'(bit_count);
      end
      default: begin
        in_cur_new = cursor;
      end
    endcase
  end

  // High bits of the first byte that a write keeps.
  assign keep_mask = BYTE_W'(16'hFF00 >> off);

  // Single-port byte memory with a registered read.
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= sreg[WIN_W-1 -: BYTE_W];
    end else if (cmd.mem_rd || cmd.fetch) begin
      rdata <= mem[addr];
    end
  end

  // Control state: cursor, read data valid, output word valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor    <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.mem_rd | cmd.fetch;
      if (cmd.finish) begin
        cursor <= cur_new;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers of the current word.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= in_op;
      len_zero <= (in_n == '0);
      off      <= cursor[2:0];
      tail     <= 3'(4'd8 - {1'b0, in_sum[2:0]});
      left     <= in_left;
      cur_new  <= in_cur_new;
      mask     <= (in_n >= CNT_W'(FIELD_W)) ? '1 : (FIELD_W'(1) << in_n) - FIELD_W'(1);
      fl       <= write_value << (CNT_W'(FIELD_W) - in_n);
      if (in_op == OP_STORE) begin
        addr <= ADDR_W'(byte_address);
        sreg <= {byte_value, {FIELD_W{1'b0}}};
      end else begin
        addr <= cursor[CUR_W-1:3];
      end
    end
    if (cmd.mem_rd) begin
      addr <= addr + ADDR_W'(1);
      left <= left - NB_W'(1);
    end
    if (cmd.mem_wr) begin
      addr <= addr + ADDR_W'(1);
      left <= left - NB_W'(1);
      sreg <= sreg << BYTE_W;
    end
    // Splice kept leading bits, the field and cleared trailing bits.
    if (cmd.build) begin
      sreg <= {rdata & keep_mask, {FIELD_W{1'b0}}} | ({fl, {BYTE_W{1'b0}}} >> off);
    end
    if (rd_valid) begin
      acc <= {acc[WIN_W-BYTE_W-1:0], rdata};
    end
    if (cmd.finish) begin
      read_value      <= (op == OP_READ) ? (FIELD_W'(acc >> tail) & mask) : '0;
      cursor_position <= BOFF_W'(cur_new);
    end
  end

  // Status to the controller.
  always_comb begin
    sts.op        = op;
    sts.len_zero  = len_zero;
    sts.left_zero = (left == '0);
    sts.rd_valid  = rd_valid;
    sts.out_free  = !out_valid || !out_stall;
  end

endmodule
`default_nettype wire

/* hw/rtl/msbfa_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msbfa_ctrl: controller of the bit field access unit
// Sequences the byte memory accesses of each command and hands the
// finished word to the output register.
// ----------------------------------------------------------------------------
module msbfa_ctrl import msbfa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts.op)
          OP_STORE: state_next = ST_WRITE;
          OP_READ:  state_next = ST_READ;
          OP_WRITE: state_next = sts.len_zero ? ST_FINISH : ST_FETCH;
          default:  state_next = ST_FINISH;
        endcase
      end
      ST_READ: begin
        // Issue one byte a cycle; leave once the last byte is captured.
        cmd.mem_rd = !sts.left_zero;
        if (sts.left_zero && !sts.rd_valid) begin
          state_next = ST_FINISH;
        end
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = ST_BUILD;
      end
      ST_BUILD: begin
        cmd.build  = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (!sts.left_zero) begin
          cmd.mem_wr = 1'b1;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mem_wr && (cmd.mem_rd || cmd.fetch)))
    else $error("byte memory read and written in the same cycle");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state == ST_DISPATCH)
    else $error("accepted word not dispatched");

  a_fetch_data: assert property (@(posedge clk) disable iff (rst)
    cmd.fetch |=> (state == ST_BUILD && sts.rd_valid))
    else $error("first byte of a write not available for splicing");

  a_zero_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE && sts.op == OP_WRITE) |-> !sts.len_zero)
    else $error("zero-length write reached the memory");
`endif

endmodule
`default_nettype wire

/* hw/rtl/msb_first_bit_field_access.sv */
// Steps: a store goes through dispatch, write and finish; a read through
// dispatch, read and finish; a write through dispatch, fetch, build, write and
// finish. A field read or write moves the nb bytes the field spans (up to 9).
// Seek, skip and a zero-length write go from dispatch to finish. One word is
// handled at a time; the single-port byte memory moves one byte per cycle.
// Reset clears the cursor and out_valid; the byte buffer is not cleared.
`default_nettype none
// ----------------------------------------------------------------------------
// msb_first_bit_field_access: MSB-first bit field reader and writer
// Bit-addressed read, write and skip of fields up to 64 bits over a byte
// buffer, with byte store and cursor seek.
// ----------------------------------------------------------------------------
module msb_first_bit_field_access import msbfa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   command,
  input  logic [BADDR_W-1:0] byte_address,
  input  logic [BYTE_W-1:0]  byte_value,
  input  logic [BOFF_W-1:0]  seek_position,
  input  logic [CNT_W-1:0]   bit_count,
  input  logic [FIELD_W-1:0] write_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FIELD_W-1:0] read_value,
  output logic [BOFF_W-1:0]  cursor_position
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // Command sequencer.
  msbfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Memory, cursor and field datapath.
  msbfa_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .command         (command),
    .byte_address    (byte_address),
    .byte_value      (byte_value),
    .seek_position   (seek_position),
    .bit_count       (bit_count),
    .write_value     (write_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .read_value      (read_value),
    .cursor_position (cursor_position)
  );

endmodule
`default_nettype wire
